// File: rtl/tora_pkg.sv
// Shared types and constants for the touch outlier-reject averager.
// Used by tora_regs, tora_core and touch_outlier_reject_average.
package tora_pkg;

    // Fixed field widths
    localparam int IN_W    = 13;
    localparam int OUT_W   = 12;
    localparam int STEP_W  = 24;
    localparam int LIMIT_W = 3;
    localparam int MISS_W  = 3;

    // Configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_STEP  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_LIMIT = 3'd4;

    // Register select, taken from the word-address bit
    localparam logic REG_SEL_STEP  = 1'b0;
    localparam logic REG_SEL_LIMIT = 1'b1;

    // Reset values
    localparam logic [STEP_W-1:0]  STEP_RST  = 24'd1800;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 3'd3;

    typedef struct packed {
        logic [STEP_W-1:0]  step_distance_sq;
        logic [LIMIT_W-1:0] miss_limit;
    } t_cfg;

    typedef struct packed {
        logic             emit;
        logic [OUT_W-1:0] avg_x;
        logic [OUT_W-1:0] avg_y;
    } t_result;

endpackage

// File: rtl/touch_outlier_reject_average.sv
// Result path: the input register takes an item, then the single-pass datapath loads the
// result register and raises o_valid when that item completes an average.
// Throughput: one item per cycle while results are taken; when a result waits,
// the input register holds one more item and then o_ready drops.
// Reset (i_rst_n low, synchronous): no reference, miss and fill counts zero,
// registers at step_distance_sq = 1800 and miss_limit = 3; no clearing pass.
module touch_outlier_reject_average #(
    parameter int AVG_COUNT  = 3,
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input items
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [tora_pkg::IN_W-1:0]  i_pos_x,
    input  logic signed [tora_pkg::IN_W-1:0]  i_pos_y,
    // Result items
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tora_pkg::OUT_W-1:0]        o_avg_x,
    output logic [tora_pkg::OUT_W-1:0]        o_avg_y,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tora_pkg::ADDR_W-1:0]       paddr,
    input  logic [tora_pkg::DATA_W-1:0]       pwdata,
    output logic [tora_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);

    tora_pkg::t_cfg                 cfg;
    tora_pkg::t_result              result;

    logic                           r_in_vld;
    logic [tora_pkg::IN_W-1:0]      r_in_x, r_in_y;
    logic                           r_out_vld;
    logic [tora_pkg::OUT_W-1:0]     r_out_x, r_out_y;
    logic                           advance;
    logic                           in_take;

    tora_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Process the held item when the result register can take its result
    assign advance = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || advance;
    assign in_take = i_valid && o_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_x <= i_pos_x;
            r_in_y <= i_pos_y;
        end
    end

    tora_core #(
        .AVG_COUNT  (AVG_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_advance (advance),
        .i_pos_x   (r_in_x),
        .i_pos_y   (r_in_y),
        .o_result  (result)
    );

    // Result register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && result.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.emit) begin
            r_out_x <= result.avg_x;
            r_out_y <= result.avg_y;
        end
    end

    assign o_valid = r_out_vld;
    assign o_avg_x = r_out_x;
    assign o_avg_y = r_out_y;

endmodule

// File: rtl/tora_regs.sv
// Configuration register file behind the APB-style port.
// Depends on tora_pkg for widths, addresses and the t_cfg struct.
module tora_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tora_pkg::ADDR_W-1:0]   paddr,
    input  logic [tora_pkg::DATA_W-1:0]   pwdata,
    output logic [tora_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output tora_pkg::t_cfg                o_cfg
);

    logic [tora_pkg::STEP_W-1:0]  r_step;
    logic [tora_pkg::LIMIT_W-1:0] r_limit;
    logic                         wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= tora_pkg::STEP_RST;
            r_limit <= tora_pkg::LIMIT_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                tora_pkg::REG_SEL_STEP:  r_step  <= pwdata[tora_pkg::STEP_W-1:0];
                tora_pkg::REG_SEL_LIMIT: r_limit <= pwdata[tora_pkg::LIMIT_W-1:0];
                default:                 r_step  <= r_step;
            endcase
        end
    end

    // Read back
    always_comb begin
        priority if (paddr == tora_pkg::ADDR_STEP) begin
            prdata = tora_pkg::DATA_W'(r_step);
        end else if (paddr == tora_pkg::ADDR_LIMIT) begin
            prdata = tora_pkg::DATA_W'(r_limit);
        end else begin
            prdata = '0;
        end
    end

    assign o_cfg.step_distance_sq = r_step;
    assign o_cfg.miss_limit       = r_limit;

endmodule

// File: rtl/tora_core.sv
// Filter state and single-pass datapath: distance check, sample store, mean.
// Depends on tora_pkg for field widths and the t_cfg / t_result structs.
module tora_core #(
    parameter int AVG_COUNT  = 3,
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tora_pkg::t_cfg              i_cfg,
    input  logic                        i_advance,
    input  logic [tora_pkg::IN_W-1:0]   i_pos_x,
    input  logic [tora_pkg::IN_W-1:0]   i_pos_y,
    output tora_pkg::t_result           o_result
);

    localparam int MAG_W   = tora_pkg::IN_W - 1;
    localparam int CLAMP_W = (COORD_BITS > MAG_W) ? COORD_BITS : MAG_W;
    localparam logic [CLAMP_W-1:0] COORD_MAX =
        CLAMP_W'((64'd1 << COORD_BITS) - 64'd1);

    localparam int FILL_W = (AVG_COUNT > 1) ? $clog2(AVG_COUNT) : 1;
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(AVG_COUNT - 1);

    // Mean via reciprocal multiply: floor(s / N) = (s * RECIP) >> SHIFT
    localparam int SUM_W   = COORD_BITS + $clog2(AVG_COUNT);
    localparam int SHIFT   = SUM_W + $clog2(AVG_COUNT);
    localparam int RECIP_W = SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(AVG_COUNT) - 64'd1) / 64'(AVG_COUNT));
    localparam int PROD_W  = SUM_W + RECIP_W;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = SQ_W + 1;
    localparam int LIM_W  = tora_pkg::MISS_W + 1 + tora_pkg::STEP_W;
    localparam int CMP_W  = (DIST_W > LIM_W) ? DIST_W : LIM_W;

    // State
    logic [COORD_BITS-1:0]        r_ref_x, r_ref_y;
    logic                         r_ref_vld;
    logic [tora_pkg::MISS_W-1:0]  r_miss;
    logic [FILL_W-1:0]            r_fill;
    logic [COORD_BITS-1:0]        r_store_x [AVG_COUNT];
    logic [COORD_BITS-1:0]        r_store_y [AVG_COUNT];

    logic [tora_pkg::MISS_W-1:0]  n_miss;
    logic [FILL_W-1:0]            n_fill;
    logic                         n_ref_vld;

    logic                         coord_neg;
    logic [CLAMP_W-1:0]           wide_x, wide_y;
    logic [COORD_BITS-1:0]        cx, cy;
    logic [COORD_BITS-1:0]        ex, ey;
    logic [COORD_BITS-1:0]        dx, dy;
    logic [SQ_W-1:0]              sq_x, sq_y;
    logic [CMP_W-1:0]             dist_sq, lim;
    logic [tora_pkg::MISS_W:0]    miss_inc;
    logic                         reset_due;
    logic                         in_range;
    logic                         take;
    logic                         emit;
    logic [SUM_W-1:0]             sum_x, sum_y;
    logic [PROD_W-1:0]            prod_x, prod_y;

    // Sign check and saturation into the coordinate range
    assign coord_neg = i_pos_x[tora_pkg::IN_W-1] | i_pos_y[tora_pkg::IN_W-1];
    assign wide_x = CLAMP_W'(i_pos_x[MAG_W-1:0]);
    assign wide_y = CLAMP_W'(i_pos_y[MAG_W-1:0]);
    assign cx = COORD_BITS'((wide_x > COORD_MAX) ? COORD_MAX : wide_x);
    assign cy = COORD_BITS'((wide_y > COORD_MAX) ? COORD_MAX : wide_y);

    // Reference: the sample itself when none is held yet
    assign ex = r_ref_vld ? r_ref_x : cx;
    assign ey = r_ref_vld ? r_ref_y : cy;

    // Squared distance against scaled threshold
    assign dx      = (cx >= ex) ? (cx - ex) : (ex - cx);
    assign dy      = (cy >= ey) ? (cy - ey) : (ey - cy);
    assign sq_x    = SQ_W'(dx) * SQ_W'(dx);
    assign sq_y    = SQ_W'(dy) * SQ_W'(dy);
    assign dist_sq = CMP_W'(sq_x) + CMP_W'(sq_y);

    assign miss_inc = {1'b0, r_miss} + 1'b1;
    assign lim = CMP_W'(LIM_W'(miss_inc) * LIM_W'(i_cfg.step_distance_sq));

    assign reset_due = (r_miss >= i_cfg.miss_limit);
    assign in_range  = (dist_sq <= lim);
    assign take      = i_advance && !coord_neg && !reset_due && in_range;
    assign emit      = take && (r_fill == FILL_LAST);

    // Sum the stored samples, with the current one in its slot
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < AVG_COUNT; i++) begin
            if (FILL_W'(i) == r_fill) begin
                sum_x = sum_x + SUM_W'(cx);
                sum_y = sum_y + SUM_W'(cy);
            end else begin
                sum_x = sum_x + SUM_W'(r_store_x[i]);
                sum_y = sum_y + SUM_W'(r_store_y[i]);
            end
        end
    end

    assign prod_x = PROD_W'(sum_x) * PROD_W'(RECIP);
    assign prod_y = PROD_W'(sum_y) * PROD_W'(RECIP);

    assign o_result.emit  = emit;
    assign o_result.avg_x = tora_pkg::OUT_W'(prod_x[PROD_W-1:SHIFT]);
    assign o_result.avg_y = tora_pkg::OUT_W'(prod_y[PROD_W-1:SHIFT]);

    // Next control state
    always_comb begin
        n_miss    = r_miss;
        n_fill    = r_fill;
        n_ref_vld = r_ref_vld;
        if (i_advance && !coord_neg) begin
            if (reset_due) begin
                n_miss    = '0;
                n_fill    = '0;
                n_ref_vld = 1'b0;
            end else begin
                n_ref_vld = 1'b1;
                if (!in_range) begin
                    n_miss = miss_inc[tora_pkg::MISS_W-1:0];
                end else begin
                    n_miss = '0;
                    n_fill = emit ? '0 : r_fill + 1'b1;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss    <= '0;
            r_fill    <= '0;
            r_ref_vld <= 1'b0;
        end else begin
            r_miss    <= n_miss;
            r_fill    <= n_fill;
            r_ref_vld <= n_ref_vld;
        end
    end

    // Reference point follows each stored sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
        end else if (take) begin
            r_ref_x <= cx;
            r_ref_y <= cy;
        end
    end

    // Store the sample in its fill slot
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_store_x[r_fill] <= cx;
            r_store_y[r_fill] <= cy;
        end
    end

endmodule

// File: tb/sv/tb_touch_outlier_reject_average.sv
// Self-checking testbench for touch_outlier_reject_average.
// Depends on tora_pkg and the RTL only; a scoreboard class predicts every
// average from the accepted touch items and the register settings.
module tb_touch_outlier_reject_average;
    timeunit 1ns;
    timeprecision 1ps;

    import tora_pkg::*;

    localparam int AVG_N      = 3;
    localparam int COORD_MAX  = 4095;
    localparam int QUIET_MAX  = 2000;
    localparam int LONG_HOLD  = 300;
    localparam int HOLD_PHASE = 2;
    localparam int N_PHASES   = 8;
    localparam int DIR_N      = 17;

    typedef struct {
        bit [OUT_W-1:0] x;
        bit [OUT_W-1:0] y;
    } touch_avg_t;

    // Tracks the averager state and holds the averages still to come
    class touch_avg_board;
        bit [STEP_W-1:0]  step_dist_sq = STEP_RST;
        bit [LIMIT_W-1:0] miss_limit   = LIMIT_RST;
        bit [OUT_W-1:0]   anchor_x, anchor_y;
        bit               anchor_ok;
        bit [MISS_W-1:0]  misses;
        int unsigned      filled;
        bit [OUT_W-1:0]   held_x [AVG_N];
        bit [OUT_W-1:0]   held_y [AVG_N];
        touch_avg_t       expected_avgs [$];
        int               errors;

        function void set_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            if (addr == ADDR_STEP)
                step_dist_sq = data[STEP_W-1:0];
            else if (addr == ADDR_LIMIT)
                miss_limit = data[LIMIT_W-1:0];
        endfunction

        function int pending();
            return expected_avgs.size();
        endfunction

        // Advance the state by one accepted touch item
        function void note_touch(logic signed [IN_W-1:0] px, logic signed [IN_W-1:0] py);
            bit [OUT_W-1:0]  x, y;
            int              dx, dy;
            longint unsigned dist_sq, allowed;
            int unsigned     sum_x, sum_y;
            touch_avg_t      avg;
            // drop invalid touches without any state change
            if (px < 0 || py < 0)
                return;
            // 13-bit non-negative values never exceed the 12-bit range
            x = px[OUT_W-1:0];
            y = py[OUT_W-1:0];
            if (!anchor_ok) begin
                anchor_x  = x;
                anchor_y  = y;
                anchor_ok = 1'b1;
            end
            // too many misses: start over and drop this touch
            if (misses >= miss_limit) begin
                misses    = '0;
                anchor_ok = 1'b0;
                filled    = 0;
                return;
            end
            dx      = int'(x) - int'(anchor_x);
            dy      = int'(y) - int'(anchor_y);
            dist_sq = longint'(dx * dx) + longint'(dy * dy);
            allowed = longint'(misses + 1) * longint'(step_dist_sq);
            if (dist_sq > allowed) begin
                misses = misses + 1'b1;
                return;
            end
            held_x[filled] = x;
            held_y[filled] = y;
            filled++;
            anchor_x = x;
            anchor_y = y;
            misses   = '0;
            if (filled < AVG_N)
                return;
            sum_x = 0;
            sum_y = 0;
            for (int i = 0; i < AVG_N; i++) begin
                sum_x += held_x[i];
                sum_y += held_y[i];
            end
            avg.x = OUT_W'(sum_x / AVG_N);
            avg.y = OUT_W'(sum_y / AVG_N);
            expected_avgs.push_back(avg);
            filled = 0;
        endfunction

        // Compare one result item with the oldest expected average
        function void check_avg(logic [OUT_W-1:0] ax, logic [OUT_W-1:0] ay);
            touch_avg_t want;
            if (expected_avgs.size() == 0) begin
                $display("%0t: result (%0d,%0d) with no average expected", $time, ax, ay);
                errors++;
                return;
            end
            want = expected_avgs.pop_front();
            if (ax !== want.x) begin
                $display("%0t: avg_x expected %0d got %0d", $time, want.x, ax);
                errors++;
            end
            if (ay !== want.y) begin
                $display("%0t: avg_y expected %0d got %0d", $time, want.y, ay);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic signed [IN_W-1:0]  i_pos_x = '0;
    logic signed [IN_W-1:0]  i_pos_y = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [OUT_W-1:0]        o_avg_x;
    logic [OUT_W-1:0]        o_avg_y;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [ADDR_W-1:0]       paddr   = '0;
    logic [DATA_W-1:0]       pwdata  = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;

    touch_avg_board board = new();

    int send_idle_pct = 0;
    int rcv_stall_pct = 0;
    int hold_reqs     = 0;
    int holds_done    = 0;
    int quiet_cycles  = 0;

    // Directed touches: extremes, ignored items, miss build-up and reset,
    // distance exactly at the threshold, just past it, and scaled by misses
    int dir_x [DIR_N] = '{0, -1, 5, 10, 20, 4095, 4095, 0, 30,
                          4095, 4095, 4065, 4035, 4000, 3975, 3975, -4096};
    int dir_y [DIR_N] = '{0, 5, -4096, 10, 20, 4095, 0, 4095, 30,
                          4095, 4095, 4095, 4065, 4041, 4065, 4065, -1};

    // Per-phase register settings; -1 picks a random value
    int ph_step  [N_PHASES] = '{1800, 0, 16777215, -1, 50, 600, -1, 5000};
    int ph_limit [N_PHASES] = '{3, 1, 7, -1, 2, 0, -1, 5};
    int ph_items [N_PHASES] = '{130, 110, 130, 130, 130, 40, 130, 150};

    touch_outlier_reject_average dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_avg_x (o_avg_x),
        .o_avg_y (o_avg_y),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Observe both channels at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                board.note_touch(i_pos_x, i_pos_y);
            if (o_valid && i_ready)
                board.check_avg(o_avg_x, o_avg_y);
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("%0t: no item accepted for %0d cycles", $time, QUIET_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Offer one touch item and hold it until accepted
    task automatic send_touch(input logic signed [IN_W-1:0] px,
                              input logic signed [IN_W-1:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop sending and wait for every expected average plus the pipeline
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup cycle, access cycle, then back to idle
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        board.set_reg(addr, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int                     sent, roll, burst_left, radius;
        int                     cx, cy, nx, ny, step_val, limit_val;
        bit                     hold_asked;
        logic signed [IN_W-1:0] px, py;

        hold_asked = 1'b0;
        burst_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at reset settings
        for (int i = 0; i < DIR_N; i++)
            send_touch(IN_W'(dir_x[i]), IN_W'(dir_y[i]));
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            step_val  = (ph_step[p] < 0) ?
                        int'($urandom_range(0, (1 << $urandom_range(4, STEP_W)) - 1)) :
                        ph_step[p];
            limit_val = (ph_limit[p] < 0) ? int'($urandom_range(1, 7)) : ph_limit[p];
            write_reg(ADDR_STEP, DATA_W'(step_val));
            write_reg(ADDR_LIMIT, DATA_W'(limit_val));
            case (p % 4)
                0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; rcv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  rcv_stall_pct = 47; end
                default: begin send_idle_pct = 33; rcv_stall_pct = 33; end
            endcase
            // per-axis step that keeps a move within the threshold
            radius = int'($floor($sqrt(real'(step_val) / 2.0)));
            if (radius > COORD_MAX)
                radius = COORD_MAX;
            cx   = $urandom_range(0, COORD_MAX);
            cy   = $urandom_range(0, COORD_MAX);
            sent = 0;

            while (sent < ph_items[p]) begin
                roll = $urandom_range(99);
                if (burst_left > 0) begin
                    // keep up a run of far-off touches
                    px = IN_W'($urandom_range(0, COORD_MAX));
                    py = IN_W'($urandom_range(0, COORD_MAX));
                    burst_left--;
                end else if (roll < 6) begin
                    // raw noise over the full field range
                    px = IN_W'($urandom_range(0, (1 << IN_W) - 1));
                    py = IN_W'($urandom_range(0, (1 << IN_W) - 1));
                end else if (roll < 14) begin
                    // invalid touch: at least one negative coordinate
                    px = IN_W'(-int'($urandom_range(1, 4096)));
                    py = $urandom_range(1) ? IN_W'(-int'($urandom_range(1, 4096))) :
                                             IN_W'($urandom_range(0, COORD_MAX));
                    if ($urandom_range(1)) begin
                        nx = px;
                        px = py;
                        py = IN_W'(nx);
                    end
                end else if (roll < 22) begin
                    // single outlier
                    px = IN_W'($urandom_range(0, COORD_MAX));
                    py = IN_W'($urandom_range(0, COORD_MAX));
                end else if (roll < 26) begin
                    // outlier burst of two to nine far-off touches, which can reach the miss limit
                    px = IN_W'($urandom_range(0, COORD_MAX));
                    py = IN_W'($urandom_range(0, COORD_MAX));
                    burst_left = $urandom_range(1, 8);
                end else if (roll < 30) begin
                    // lift and touch down somewhere new
                    cx = $urandom_range(0, COORD_MAX);
                    cy = $urandom_range(0, COORD_MAX);
                    px = IN_W'(cx);
                    py = IN_W'(cy);
                end else begin
                    // follow the stroke with a small move
                    nx = cx + int'($urandom_range(0, 2 * radius)) - radius;
                    ny = cy + int'($urandom_range(0, 2 * radius)) - radius;
                    cx = (nx < 0) ? 0 : ((nx > COORD_MAX) ? COORD_MAX : nx);
                    cy = (ny < 0) ? 0 : ((ny > COORD_MAX) ? COORD_MAX : ny);
                    px = IN_W'(cx);
                    py = IN_W'(cy);
                end
                send_touch(px, py);
                sent++;
                // hold off the receiver while the sender keeps pushing
                if (p == HOLD_PHASE && sent == 40 && !hold_asked) begin
                    hold_asked = 1'b1;
                    hold_reqs++;
                end
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
